// ===== sv/sabs_pkg.sv =====
// ---------------------------------------------------------------------------
// sabs_pkg
// Shared types and constants for the sort and binary search core.
// ---------------------------------------------------------------------------
package sabs_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int VALUE_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;
   localparam int FIDX_W   = 4;

   localparam logic [MODE_W-1:0] MODE_APPEND = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_IGNORE = 2'd3;

   localparam logic [STATUS_W-1:0] ST_APPENDED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_FOUND    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CLEARED  = 3'd4;

   typedef struct packed {
      logic [MODE_W-1:0]         mode;
      logic signed [VALUE_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [FIDX_W-1:0]   found_index;
   } rsp_type;

   typedef enum logic [3:0] {
      DP_NOP,
      DP_APPEND,
      DP_CLEAR,
      DP_SEARCH,
      DP_RD0,
      DP_LOAD,
      DP_SWAP,
      DP_WB,
      DP_PROBE,
      DP_CMP,
      DP_RESP
   } dp_op_type;

   typedef struct packed {
      dp_op_type           op;
      logic [STATUS_W-1:0] rsp_status;
   } dp_cmd_type;

   typedef struct packed {
      logic full;
      logic sorted;
      logic few_elems;
      logic last_elem;
      logic last_pass;
      logic range_empty;
      logic hit;
   } dp_stat_type;

endpackage

// ===== sv/sabs_ram.sv =====
// ---------------------------------------------------------------------------
// sabs_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module sabs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== sv/sabs_dp.sv =====
// ---------------------------------------------------------------------------
// sabs_dp
// Datapath: value store, element count, sort pass counters, search bounds
// and the result register.
// ---------------------------------------------------------------------------
module sabs_dp (
   input  logic                           clock,
   input  logic                           reset,
   input  sabs_pkg::dp_cmd_type           cmd,
   input  logic signed [sabs_pkg::VALUE_W-1:0] req_value,
   output sabs_pkg::dp_stat_type          stat,
   output sabs_pkg::rsp_type              rsp_data
);

   localparam int IDX_W   = sabs_pkg::IDX_W;
   localparam int CNT_W   = sabs_pkg::CNT_W;
   localparam int VALUE_W = sabs_pkg::VALUE_W;

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               sorted_ff, sorted_in;
   logic [CNT_W-1:0]   low_ff, low_in;
   logic [CNT_W-1:0]   high_p1_ff, high_p1_in;
   logic [IDX_W-1:0]   mid_ff, mid_in;
   logic [IDX_W-1:0]   j_ff, j_in;
   logic [IDX_W-1:0]   pass_ff, pass_in;
   logic [VALUE_W-1:0] acc_ff, acc_in;
   logic [VALUE_W-1:0] target_ff, target_in;
   sabs_pkg::rsp_type  rsp_ff, rsp_in;

   logic               ram_we;
   logic [IDX_W-1:0]   ram_waddr;
   logic [VALUE_W-1:0] ram_wdata;
   logic [IDX_W-1:0]   ram_raddr;
   logic [VALUE_W-1:0] ram_rdata;

   logic [CNT_W-1:0]   count_m1;
   logic [CNT_W-1:0]   count_m2;
   logic [CNT_W:0]     mid_sum;
   logic               probe_less;

   sabs_ram #(
      .WIDTH(VALUE_W),
      .DEPTH(sabs_pkg::CAPACITY)
   ) u_store (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   assign count_m1   = count_ff - CNT_W'(1);
   assign count_m2   = count_ff - CNT_W'(2);
   assign mid_sum    = {1'b0, low_ff} + {1'b0, high_p1_ff} - (CNT_W + 1)'(1);
   assign probe_less = $signed(ram_rdata) < $signed(target_ff);

   always_comb begin
      count_in   = count_ff;
      sorted_in  = sorted_ff;
      low_in     = low_ff;
      high_p1_in = high_p1_ff;
      mid_in     = mid_ff;
      j_in       = j_ff;
      pass_in    = pass_ff;
      acc_in     = acc_ff;
      target_in  = target_ff;
      rsp_in     = rsp_ff;
      ram_we     = 1'b0;
      ram_waddr  = j_ff - IDX_W'(1);
      ram_wdata  = acc_ff;
      ram_raddr  = j_ff;
      unique case (cmd.op)
         sabs_pkg::DP_APPEND: begin
            ram_we    = 1'b1;
            ram_waddr = count_ff[IDX_W-1:0];
            ram_wdata = req_value;
            count_in  = count_ff + CNT_W'(1);
            sorted_in = 1'b0;
         end
         sabs_pkg::DP_CLEAR: begin
            count_in  = '0;
            sorted_in = 1'b1;
         end
         sabs_pkg::DP_SEARCH: begin
            target_in  = req_value;
            low_in     = '0;
            high_p1_in = count_ff;
            pass_in    = '0;
            sorted_in  = 1'b1;
         end
         sabs_pkg::DP_RD0: begin
            ram_raddr = '0;
            j_in      = IDX_W'(1);
         end
         sabs_pkg::DP_LOAD: begin
            acc_in    = ram_rdata;
            ram_raddr = j_ff;
         end
         sabs_pkg::DP_SWAP: begin
            ram_we    = 1'b1;
            ram_waddr = j_ff - IDX_W'(1);
            if ($signed(ram_rdata) < $signed(acc_ff)) begin
               ram_wdata = ram_rdata;
            end else begin
               ram_wdata = acc_ff;
               acc_in    = ram_rdata;
            end
            ram_raddr = j_ff + IDX_W'(1);
            j_in      = j_ff + IDX_W'(1);
         end
         sabs_pkg::DP_WB: begin
            ram_we    = 1'b1;
            ram_waddr = count_m1[IDX_W-1:0];
            ram_wdata = acc_ff;
            pass_in   = pass_ff + IDX_W'(1);
         end
         sabs_pkg::DP_PROBE: begin
            mid_in    = mid_sum[IDX_W:1];
            ram_raddr = mid_sum[IDX_W:1];
         end
         sabs_pkg::DP_CMP: begin
            if (ram_rdata != target_ff) begin
               if (probe_less) begin
                  low_in = CNT_W'(mid_ff) + CNT_W'(1);
               end else begin
                  high_p1_in = CNT_W'(mid_ff);
               end
            end
         end
         sabs_pkg::DP_RESP: begin
            rsp_in.status = cmd.rsp_status;
            if (cmd.rsp_status == sabs_pkg::ST_FOUND) begin
               rsp_in.found_index = sabs_pkg::FIDX_W'(mid_ff);
            end else begin
               rsp_in.found_index = '0;
            end
         end
         sabs_pkg::DP_NOP: begin
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         sorted_ff  <= 1'b1;
         low_ff     <= '0;
         high_p1_ff <= '0;
         j_ff       <= '0;
         pass_ff    <= '0;
      end else begin
         count_ff   <= count_in;
         sorted_ff  <= sorted_in;
         low_ff     <= low_in;
         high_p1_ff <= high_p1_in;
         j_ff       <= j_in;
         pass_ff    <= pass_in;
      end
      mid_ff    <= mid_in;
      acc_ff    <= acc_in;
      target_ff <= target_in;
      rsp_ff    <= rsp_in;
   end

   assign stat.full        = (count_ff == CNT_W'(sabs_pkg::CAPACITY));
   assign stat.sorted      = sorted_ff;
   assign stat.few_elems   = (count_ff < CNT_W'(2));
   assign stat.last_elem   = (j_ff == count_m1[IDX_W-1:0]);
   assign stat.last_pass   = (pass_ff == count_m2[IDX_W-1:0]);
   assign stat.range_empty = (low_ff >= high_p1_ff);
   assign stat.hit         = (ram_rdata == target_ff);

   assign rsp_data = rsp_ff;

endmodule

// ===== sv/sabs_ctrl.sv =====
// ---------------------------------------------------------------------------
// sabs_ctrl
// Controller: decodes each request beat and steps the datapath through
// append, clear, bubble sort passes and binary search probes.
// ---------------------------------------------------------------------------
module sabs_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [sabs_pkg::MODE_W-1:0]   req_mode,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output sabs_pkg::dp_cmd_type          cmd,
   input  sabs_pkg::dp_stat_type         stat
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_SORT_RD0,
      S_SORT_LD,
      S_SORT_CMP,
      S_SORT_WB,
      S_SRCH_CHK,
      S_SRCH_CMP,
      S_RESP
   } state_type;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [sabs_pkg::STATUS_W-1:0] status_ff, status_in;

   always_comb begin
      state_in       = state_ff;
      status_in      = status_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      cmd.op         = sabs_pkg::DP_NOP;
      cmd.rsp_status = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_mode)
                  sabs_pkg::MODE_APPEND: begin
                     if (stat.full) begin
                        status_in = sabs_pkg::ST_FULL;
                     end else begin
                        cmd.op    = sabs_pkg::DP_APPEND;
                        status_in = sabs_pkg::ST_APPENDED;
                     end
                     state_in = S_RESP;
                  end
                  sabs_pkg::MODE_CLEAR: begin
                     cmd.op    = sabs_pkg::DP_CLEAR;
                     status_in = sabs_pkg::ST_CLEARED;
                     state_in  = S_RESP;
                  end
                  sabs_pkg::MODE_SEARCH: begin
                     cmd.op = sabs_pkg::DP_SEARCH;
                     if (stat.sorted || stat.few_elems) begin
                        state_in = S_SRCH_CHK;
                     end else begin
                        state_in = S_SORT_RD0;
                     end
                  end
                  sabs_pkg::MODE_IGNORE: begin
                     state_in = S_IDLE;
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_SORT_RD0: begin
            cmd.op   = sabs_pkg::DP_RD0;
            state_in = S_SORT_LD;
         end
         S_SORT_LD: begin
            cmd.op   = sabs_pkg::DP_LOAD;
            state_in = S_SORT_CMP;
         end
         S_SORT_CMP: begin
            cmd.op = sabs_pkg::DP_SWAP;
            if (stat.last_elem) begin
               state_in = S_SORT_WB;
            end
         end
         S_SORT_WB: begin
            cmd.op = sabs_pkg::DP_WB;
            if (stat.last_pass) begin
               state_in = S_SRCH_CHK;
            end else begin
               state_in = S_SORT_RD0;
            end
         end
         S_SRCH_CHK: begin
            if (stat.range_empty) begin
               status_in = sabs_pkg::ST_MISSING;
               state_in  = S_RESP;
            end else begin
               cmd.op   = sabs_pkg::DP_PROBE;
               state_in = S_SRCH_CMP;
            end
         end
         S_SRCH_CMP: begin
            cmd.op = sabs_pkg::DP_CMP;
            if (stat.hit) begin
               status_in = sabs_pkg::ST_FOUND;
               state_in  = S_RESP;
            end else begin
               state_in = S_SRCH_CHK;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.op       = sabs_pkg::DP_RESP;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         status_ff    <= sabs_pkg::ST_APPENDED;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         status_ff    <= status_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== sv/sort_and_binary_search_core.sv =====
// Append and clear: S_RESP registers the result once any earlier one is taken, then goes idle.
// Mode three beats are taken in S_IDLE and give no result.
// Search: after the accept, bubble sort passes run when a value was appended since the last sort
// and n >= 2 (n = stored elements); each probe steps S_SRCH_CHK and S_SRCH_CMP, then S_RESP.
// One item at a time; one RAM read per cycle sets the sort to one compare-swap per cycle.
// A finished result waits in its register. Synchronous reset empties the store, marks it sorted.
// ---------------------------------------------------------------------------
// sort_and_binary_search_core
// Store of signed values with bubble sort and binary search on request.
// ---------------------------------------------------------------------------
module sort_and_binary_search_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  sabs_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output sabs_pkg::rsp_type rsp_data
);

   sabs_pkg::dp_cmd_type  cmd;
   sabs_pkg::dp_stat_type stat;

   sabs_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_mode (req_data.mode),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .cmd      (cmd),
      .stat     (stat)
   );

   sabs_dp u_dp (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_value(req_data.value),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule
